>>> sv/bloom_filter_bit_store_assert.svh
// Assertion macros shared by the bit store modules
`ifndef BLOOM_FILTER_BIT_STORE_ASSERT_SVH
`define BLOOM_FILTER_BIT_STORE_ASSERT_SVH
`ifndef ASSERT_OFF
`define BFBS_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("bit store assertion failed");
`define BFBS_ASSERT_ALWAYS(lbl, prop) \
	lbl: assert property (@(posedge clk) (prop)) \
		else $error("bit store check failed");
`else
`define BFBS_ASSERT(lbl, prop)
`define BFBS_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

>>> sv/bfbs_pkg.sv
// Types and constants of the Bloom filter bit store
package bfbs_pkg;

	localparam int MAX_BITS    = 4096;
	localparam int WORD_W      = 64;
	localparam int BIT_W       = $clog2(WORD_W);
	localparam int WORD_COUNT  = (MAX_BITS + WORD_W - 1) / WORD_W;
	localparam int WORD_AW     = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;

	localparam int HASH_W      = 64;
	localparam int FB_W        = 13;
	localparam logic [FB_W-1:0] FB_RESET = 13'd4096;

	// remainder is below the modulus, the modulus is at most MAX_BITS
	localparam int MOD_W       = $clog2(MAX_BITS) + 1;
	localparam int CMP_W       = (FB_W > MOD_W) ? FB_W : MOD_W;

	// remainder unit takes this many hash bits per cycle
	localparam int DIGITS      = 4;
	localparam int STEPS       = HASH_W / DIGITS;
	localparam int CNT_W       = (STEPS > 1) ? $clog2(STEPS) : 1;

	localparam int QDEPTH      = 2;
	localparam int QAW         = $clog2(QDEPTH);

	typedef struct packed {
		logic                is_query;
		logic                last;
		logic [WORD_AW-1:0]  word;
		logic [BIT_W-1:0]    bitpos;
	} job_t;

endpackage

>>> sv/bfbs_ram.sv
// Generic single write port RAM with registered read
module bfbs_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> sv/bfbs_front.sv
// Front end: accepts hash beats, reduces the hash modulo the filter size
module bfbs_front import bfbs_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              hash_valid,
	output logic              hash_stall,
	input  logic              mode,
	input  logic [HASH_W-1:0] hash_value,
	input  logic              last_hash,
	input  logic              filter_bits_we,
	input  logic [FB_W-1:0]   filter_bits_wdata,
	output logic              push,
	output job_t              push_job,
	input  logic              q_full
);

	logic [FB_W-1:0]   filter_bits_q;
	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [HASH_W-1:0] hash_q;
	logic [MOD_W-1:0]  rem_q;
	logic [MOD_W-1:0]  mod_q;
	logic              is_query_q;
	logic              last_q;

	logic              accept;
	logic [CMP_W-1:0]  fb_x;
	logic [MOD_W-1:0]  eff_mod;
	logic [MOD_W-1:0]  rem_next;

	always_comb begin
		fb_x = CMP_W'(filter_bits_q);
		if (fb_x == '0) begin
			eff_mod = MOD_W'(1);
		end else if (fb_x > CMP_W'(MAX_BITS)) begin
			eff_mod = MOD_W'(MAX_BITS);
		end else begin
			eff_mod = MOD_W'(fb_x);
		end
	end

	// restoring remainder, DIGITS hash bits per cycle, msb first
	always_comb begin
		logic [MOD_W:0] t;
		rem_next = rem_q;
		for (int i = 0; i < DIGITS; i++) begin
			t = {rem_next, hash_q[HASH_W-1-i]};
			if (t >= {1'b0, mod_q}) begin
				t = t - {1'b0, mod_q};
			end
			rem_next = t[MOD_W-1:0];
		end
	end

	assign hash_stall = busy_q;
	assign accept     = hash_valid && !busy_q;
	assign push       = busy_q && done_q && !q_full;

	assign push_job.is_query = is_query_q;
	assign push_job.last     = last_q;
	assign push_job.word     = rem_q[WORD_AW+BIT_W-1:BIT_W];
	assign push_job.bitpos   = rem_q[BIT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filter_bits_q <= FB_RESET;
			busy_q        <= 1'b0;
			done_q        <= 1'b0;
			cnt_q         <= '0;
		end else begin
			if (filter_bits_we) begin
				filter_bits_q <= filter_bits_wdata;
			end
			if (accept) begin
				busy_q <= 1'b1;
				done_q <= 1'b0;
				cnt_q  <= '0;
			end else if (busy_q && !done_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(STEPS - 1)) begin
					done_q <= 1'b1;
				end
			end else if (push) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			hash_q     <= hash_value;
			rem_q      <= '0;
			mod_q      <= eff_mod;
			is_query_q <= mode;
			last_q     <= last_hash;
		end else if (busy_q && !done_q) begin
			hash_q <= hash_q << DIGITS;
			rem_q  <= rem_next;
		end
	end

endmodule

>>> sv/bfbs_queue.sv
// Short job queue between front and back
module bfbs_queue import bfbs_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	output logic full,
	input  logic pop,
	output logic q_valid,
	output job_t q_job
);

	`include "bloom_filter_bit_store_assert.svh"

	job_t            ent_q [QDEPTH];
	logic [QAW-1:0]  wr_ptr_q;
	logic [QAW-1:0]  rd_ptr_q;
	logic [QAW:0]    count_q;

	assign full    = (count_q == (QAW+1)'(QDEPTH));
	assign q_valid = (count_q != '0);
	assign q_job   = ent_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QAW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QAW'(1);
			end
			case ({push, pop})
				2'b10: count_q <= count_q + (QAW+1)'(1);
				2'b01: count_q <= count_q - (QAW+1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= push_job;
		end
	end

	`BFBS_ASSERT(a_no_overflow, !(push && full))
	`BFBS_ASSERT(a_no_underflow, pop |-> q_valid)

endmodule

>>> sv/bfbs_back.sv
// Back end: word read-modify-write, query tracking and result register
module bfbs_back import bfbs_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic q_valid,
	input  job_t q_job,
	output logic q_pop,
	output logic result_valid,
	input  logic result_stall,
	output logic absent
);

	`include "bloom_filter_bit_store_assert.svh"

	localparam logic S_IDLE = 1'b0;
	localparam logic S_EXEC = 1'b1;

	logic              state_q;
	job_t              job_q;
	logic              miss_seen_q;
	logic              result_valid_q;
	logic              absent_q;
	logic              vld_q [WORD_COUNT];

	logic [WORD_W-1:0] rdata;
	logic [WORD_W-1:0] cur_word;
	logic [WORD_W-1:0] wdata;
	logic              we;
	logic              hit;
	logic              miss;
	logic              out_free;
	logic              emit;
	logic              finish;

	bfbs_ram #(
		.WIDTH (WORD_W),
		.DEPTH (WORD_COUNT),
		.AW    (WORD_AW)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (job_q.word),
		.wdata (wdata),
		.re    (q_pop),
		.raddr (q_job.word),
		.rdata (rdata)
	);

	// a word never written since reset reads as zero
	assign cur_word = vld_q[job_q.word] ? rdata : '0;
	assign hit      = cur_word[job_q.bitpos];
	assign miss     = miss_seen_q || !hit;
	assign wdata    = cur_word | (WORD_W'(1) << job_q.bitpos);

	assign out_free = !result_valid_q || !result_stall;
	assign q_pop    = (state_q == S_IDLE) && q_valid;
	assign we       = (state_q == S_EXEC) && !job_q.is_query;
	assign emit     = (state_q == S_EXEC) && job_q.is_query && job_q.last && out_free;
	assign finish   = (state_q == S_EXEC) && (!(job_q.is_query && job_q.last) || out_free);

	assign result_valid = result_valid_q;
	assign absent       = absent_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			miss_seen_q    <= 1'b0;
			result_valid_q <= 1'b0;
			for (int i = 0; i < WORD_COUNT; i++) begin
				vld_q[i] <= 1'b0;
			end
		end else begin
			case (state_q)
				S_IDLE: begin
					if (q_pop) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (finish) begin
						state_q <= S_IDLE;
						if (job_q.last) begin
							miss_seen_q <= 1'b0;
						end else if (job_q.is_query) begin
							miss_seen_q <= miss;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
			if (we) begin
				vld_q[job_q.word] <= 1'b1;
			end
			if (emit) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			job_q <= q_job;
		end
		if (emit) begin
			absent_q <= miss;
		end
	end

	`BFBS_ASSERT(a_write_in_exec, we |-> (state_q == S_EXEC))
	`BFBS_ASSERT(a_emit_clears_miss, emit |=> (result_valid_q && !miss_seen_q))
	`BFBS_ASSERT(a_pop_then_exec, q_pop |=> (state_q == S_EXEC))

endmodule

>>> sv/bloom_filter_bit_store.sv
// Bloom filter bit store, top level. Each hash beat is reduced modulo filter_bits by a
// remainder unit that takes 4 hash bits per cycle; the front end is busy from acceptance
// until the job is handed to the queue, so it takes no new beat before it is through with
// the last one. A two-entry queue feeds the back end, which pops a job and reads its
// 64-bit word from the store RAM in the idle state, then sets or tests the bit in exec. A query beat
// with last_hash set gives one result beat once the output register is free;
// the result register lets the next hash beat enter while a result waits. The store
// reads as all zeros after reset through per-word valid bits, so there is no clearing pass.
// filter_bits of 0 acts as 1 and values above the store size act as the store size.
module bloom_filter_bit_store import bfbs_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              hash_valid,
	output logic              hash_stall,
	input  logic              mode,
	input  logic [HASH_W-1:0] hash_value,
	input  logic              last_hash,
	output logic              result_valid,
	input  logic              result_stall,
	output logic              absent,
	input  logic              filter_bits_we,
	input  logic [FB_W-1:0]   filter_bits_wdata
);

	logic push;
	job_t push_job;
	logic q_full;
	logic q_pop;
	logic q_valid;
	job_t q_job;

	bfbs_front u_front (
		.clk               (clk),
		.arst_n            (arst_n),
		.hash_valid        (hash_valid),
		.hash_stall        (hash_stall),
		.mode              (mode),
		.hash_value        (hash_value),
		.last_hash         (last_hash),
		.filter_bits_we    (filter_bits_we),
		.filter_bits_wdata (filter_bits_wdata),
		.push              (push),
		.push_job          (push_job),
		.q_full            (q_full)
	);

	bfbs_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.full     (q_full),
		.pop      (q_pop),
		.q_valid  (q_valid),
		.q_job    (q_job)
	);

	bfbs_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.q_job        (q_job),
		.q_pop        (q_pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.absent       (absent)
	);

endmodule

>>> tb/bloom_filter_bit_store_checker.sv
// Checker for the Bloom filter bit store: predicts each query result and compares
`timescale 1ns / 1ps

module bloom_filter_bit_store_checker import bfbs_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              hash_valid,
	input  logic              hash_stall,
	input  logic              mode,
	input  logic [HASH_W-1:0] hash_value,
	input  logic              last_hash,
	input  logic              result_valid,
	input  logic              result_stall,
	input  logic              absent,
	input  logic              filter_bits_we,
	input  logic [FB_W-1:0]   filter_bits_wdata,
	output int                fail_count,
	output int                pending
);

	logic [WORD_W-1:0] store_words [WORD_COUNT];
	logic              miss_seen;
	logic [FB_W-1:0]   filter_bits;
	logic              absent_due [$];

	task automatic report_mismatch(input string what);
		$display("[%0t] mismatch: %s", $time, what);
		fail_count++;
	endtask

	// hash -> word/bit of the store, under the current filter size
	function automatic job_t locate_bit(input logic m, input logic [HASH_W-1:0] h,
			input logic l);
		logic [HASH_W-1:0] modulus;
		logic [HASH_W-1:0] rem;
		job_t              job;
		if (filter_bits == '0)
			modulus = HASH_W'(1);
		else if (filter_bits > FB_W'(MAX_BITS))
			modulus = HASH_W'(MAX_BITS);
		else
			modulus = HASH_W'(filter_bits);
		rem = h % modulus;
		job.is_query = m;
		job.last     = l;
		job.word     = rem[BIT_W +: WORD_AW];
		job.bitpos   = rem[BIT_W-1:0];
		return job;
	endfunction

	task automatic apply_hash_beat(input job_t job);
		logic miss;
		if (!job.is_query) begin
			store_words[job.word][job.bitpos] = 1'b1;
			if (job.last)
				miss_seen = 1'b0;
		end else begin
			miss = miss_seen || !store_words[job.word][job.bitpos];
			if (job.last) begin
				miss_seen = 1'b0;
				absent_due.push_back(miss);
			end else begin
				miss_seen = miss;
			end
		end
	endtask

	task automatic check_result(input logic got);
		logic want;
		if (absent_due.size() == 0) begin
			report_mismatch($sformatf("result beat absent=%0b with none expected", got));
		end else begin
			want = absent_due.pop_front();
			if (got !== want)
				report_mismatch($sformatf("absent=%0b, expected %0b", got, want));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (store_words[i])
				store_words[i] = '0;
			miss_seen   = 1'b0;
			filter_bits = FB_RESET;
			absent_due.delete();
			fail_count  = 0;
			pending     = 0;
		end else begin
			if (filter_bits_we)
				filter_bits = filter_bits_wdata;
			// retire first so a beat accepted on this edge never pairs with an older result
			if (result_valid && !result_stall)
				check_result(absent);
			if (hash_valid && !hash_stall)
				apply_hash_beat(locate_bit(mode, hash_value, last_hash));
			pending = absent_due.size();
		end
	end

endmodule

>>> tb/tb_bloom_filter_bit_store.sv
// Testbench top for the Bloom filter bit store: stimulus, idling and verdict
`timescale 1ns / 1ps

module tb_bloom_filter_bit_store;
	import bfbs_pkg::*;

	localparam logic MODE_ADD   = 1'b0;
	localparam logic MODE_QUERY = 1'b1;
	localparam int   CYCLE_LIMIT  = 1_000_000;
	localparam int   SETTLE_CYCLES = 80;
	localparam int   HOLD_CYCLES  = 400;
	localparam int   PHASE_BEATS  = 100;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              hash_valid = 1'b0;
	logic              hash_stall;
	logic              mode = MODE_ADD;
	logic [HASH_W-1:0] hash_value = '0;
	logic              last_hash = 1'b0;
	logic              result_valid;
	logic              result_stall = 1'b0;
	logic              absent;
	logic              filter_bits_we = 1'b0;
	logic [FB_W-1:0]   filter_bits_wdata = '0;

	int fail_count;
	int pending;
	int cycles = 0;

	// 0: no idling, 1: sender idles, 2: receiver stalls, 3: both
	int idle_mode = 0;
	bit hold_req = 1'b0;
	bit hold_done = 1'b0;
	int hold_left = 0;

	logic [HASH_W-1:0] added_pool [$];

	always #2 clk = ~clk;

	bloom_filter_bit_store u_top (
		.clk               (clk),
		.arst_n            (arst_n),
		.hash_valid        (hash_valid),
		.hash_stall        (hash_stall),
		.mode              (mode),
		.hash_value        (hash_value),
		.last_hash         (last_hash),
		.result_valid      (result_valid),
		.result_stall      (result_stall),
		.absent            (absent),
		.filter_bits_we    (filter_bits_we),
		.filter_bits_wdata (filter_bits_wdata)
	);

	bloom_filter_bit_store_checker u_checker (
		.clk               (clk),
		.arst_n            (arst_n),
		.hash_valid        (hash_valid),
		.hash_stall        (hash_stall),
		.mode              (mode),
		.hash_value        (hash_value),
		.last_hash         (last_hash),
		.result_valid      (result_valid),
		.result_stall      (result_stall),
		.absent            (absent),
		.filter_bits_we    (filter_bits_we),
		.filter_bits_wdata (filter_bits_wdata),
		.fail_count        (fail_count),
		.pending           (pending)
	);

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_bloom_filter_bit_store NOT OK");
			$finish;
		end
	end

	// result side: random stall, plus one long hold-off so the block backs up
	always @(negedge clk) begin
		int pct;
		pct = (idle_mode == 2) ? 72 : (idle_mode == 3) ? 28 : 0;
		if (hold_req && !hold_done) begin
			hold_left = HOLD_CYCLES;
			hold_done = 1'b1;
		end
		if (hold_left > 0) begin
			result_stall <= 1'b1;
			hold_left--;
		end else begin
			result_stall <= ($urandom_range(99) < pct);
		end
	end

	function automatic logic [HASH_W-1:0] random_hash();
		return {$urandom, $urandom};
	endfunction

	// called at a falling edge, returns at the falling edge after the beat is taken
	task automatic send_beat(input logic m, input logic [HASH_W-1:0] h, input logic l);
		int pct;
		pct = (idle_mode == 1) ? 72 : (idle_mode == 3) ? 28 : 0;
		while ($urandom_range(99) < pct) begin
			hash_valid <= 1'b0;
			@(negedge clk);
		end
		hash_valid <= 1'b1;
		mode       <= m;
		hash_value <= h;
		last_hash  <= l;
		do @(posedge clk); while (hash_stall);
		@(negedge clk);
		if (m == MODE_ADD) begin
			added_pool.push_back(h);
			if (added_pool.size() > 256)
				void'(added_pool.pop_front());
		end
	endtask

	// registers change only once the block has drained
	task automatic set_filter_bits(input logic [FB_W-1:0] v);
		hash_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		filter_bits_we    <= 1'b1;
		filter_bits_wdata <= v;
		@(negedge clk);
		filter_bits_we    <= 1'b0;
	endtask

	task automatic send_random_entries(input int beats);
		int               sent;
		int               n;
		int               kind;
		logic             m;
		logic             l;
		logic [HASH_W-1:0] h;
		sent = 0;
		while (sent < beats) begin
			n    = $urandom_range(4, 1);
			kind = $urandom_range(99);
			for (int i = 0; i < n; i++) begin
				if (kind < 5) begin
					// noise: modes and entry ends at random
					m = 1'($urandom_range(1));
					l = 1'($urandom_range(1));
				end else begin
					if (kind >= 45 && kind < 55)
						m = 1'($urandom_range(1));
					else
						m = (kind < 50) ? MODE_ADD : MODE_QUERY;
					l = (i == n - 1);
				end
				if (m == MODE_QUERY && added_pool.size() != 0 && $urandom_range(99) < 60)
					h = added_pool[$urandom_range(added_pool.size() - 1)];
				else if ($urandom_range(9) == 0)
					h = HASH_W'($urandom_range(8191));
				else
					h = random_hash();
				send_beat(m, h, l);
				sent++;
			end
		end
	endtask

	initial begin
		logic [FB_W-1:0] sizes [8];
		sizes = '{13'd64, 13'd0, 13'd8191, 13'd1, 13'd4097, 13'd4096,
			FB_W'($urandom_range(4096, 1)), FB_W'($urandom_range(8191))};

		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed, at the reset filter size
		send_beat(MODE_ADD,   64'd0, 1'b1);
		send_beat(MODE_QUERY, 64'd0, 1'b1);
		send_beat(MODE_QUERY, 64'd1, 1'b1);
		send_beat(MODE_ADD,   '1,    1'b0);
		send_beat(MODE_ADD,   64'd5, 1'b1);
		send_beat(MODE_QUERY, '1,    1'b0);
		send_beat(MODE_QUERY, 64'd5, 1'b1);
		// a clear bit early in the entry carries to the last beat
		send_beat(MODE_QUERY, 64'd3, 1'b0);
		send_beat(MODE_QUERY, 64'd0, 1'b1);
		// add with last set ends the entry and drops the miss
		send_beat(MODE_QUERY, 64'd3, 1'b0);
		send_beat(MODE_ADD,   64'd7, 1'b1);
		send_beat(MODE_QUERY, 64'd0, 1'b1);
		// mixed modes inside one entry
		send_beat(MODE_ADD,   64'd4096, 1'b0);
		send_beat(MODE_QUERY, 64'h8000_0000_0000_0000, 1'b0);
		send_beat(MODE_ADD,   64'h8000_0000_0000_0000, 1'b0);
		send_beat(MODE_QUERY, 64'd4095, 1'b1);
		send_beat(MODE_QUERY, 64'h8000_0000_0000_0000, 1'b1);
		// size zero folds every hash onto bit 0
		set_filter_bits(13'd0);
		send_beat(MODE_QUERY, random_hash(), 1'b1);
		send_beat(MODE_QUERY, '1, 1'b1);
		// oversize acts as the full store
		set_filter_bits(13'd8191);
		send_beat(MODE_QUERY, '1, 1'b1);
		send_beat(MODE_QUERY, 64'd4101, 1'b1);
		send_beat(MODE_ADD,   64'd4101, 1'b1);
		send_beat(MODE_QUERY, 64'd5, 1'b1);

		for (int p = 0; p < 8; p++) begin
			set_filter_bits(sizes[p]);
			idle_mode = p % 4;
			if (p == 4)
				hold_req = 1'b1;
			send_random_entries(PHASE_BEATS);
		end

		hash_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (fail_count == 0)
			$display("tb_bloom_filter_bit_store OK");
		else
			$display("tb_bloom_filter_bit_store NOT OK");
		$finish;
	end

endmodule

>>> bloom_filter_bit_store.f
+incdir+sv
sv/bfbs_pkg.sv
sv/bfbs_ram.sv
sv/bfbs_front.sv
sv/bfbs_queue.sv
sv/bfbs_back.sv
sv/bloom_filter_bit_store.sv
tb/bloom_filter_bit_store_checker.sv
tb/tb_bloom_filter_bit_store.sv
